FILE: rtl/sacf_pkg.sv
// ---------------------------------------------------------------------------
// sacf_pkg
// Shared types and constants of the sum and add-check frame encoder.
// ---------------------------------------------------------------------------
package sacf_pkg;

    // input command codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // frame constants
    localparam logic [7:0] HEADER_BYTE    = 8'hAA;
    localparam logic [7:0] TARGET_RESET   = 8'hFF;
    localparam int         MAX_PAYLOAD_DEF = 28;

    // job queue depth, a power of two
    localparam int QUEUE_DEPTH = 2;

    // one job handed from front to back
    typedef struct packed {
        logic       is_start;   // header job, else one payload byte
        logic       close;      // emit both checks after this job
        logic [7:0] data;       // function code on start, payload byte otherwise
        logic [7:0] len;        // payload length, used on start
    } job_t;

endpackage

FILE: rtl/sacf_front.sv
// ---------------------------------------------------------------------------
// sacf_front
// Accepts commands, tracks the open frame and turns items into back-end jobs.
// ---------------------------------------------------------------------------
module sacf_front #(
    parameter int MAX_PAYLOAD = sacf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [7:0]        function_code,
    input  logic [7:0]        payload_length,
    input  logic [7:0]        payload_byte,
    input  logic              q_full,
    output logic              push_valid,
    output sacf_pkg::job_t    push_job
);

    localparam int RW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic          open_reg, open_next;
    logic [RW-1:0] remain_reg, remain_next;
    logic          accept;
    logic          len_ok;
    logic          last_byte;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign len_ok    = payload_length <= MAX_LEN;
    assign last_byte = remain_reg == RW'(1);

    // classify the item and update frame tracking
    always_comb
    begin
        open_next     = open_reg;
        remain_next   = remain_reg;
        push_valid    = 1'b0;
        push_job      = '0;
        if (accept)
        begin
            if (command == sacf_pkg::CMD_START)
            begin
                if (len_ok)
                begin
                    push_valid        = 1'b1;
                    push_job.is_start = 1'b1;
                    push_job.close    = payload_length == 8'd0;
                    push_job.data     = function_code;
                    push_job.len      = payload_length;
                    open_next         = payload_length != 8'd0;
                    remain_next       = payload_length[RW-1:0];
                end
            end
            else if (open_reg)
            begin
                push_valid        = 1'b1;
                push_job.is_start = 1'b0;
                push_job.close    = last_byte;
                push_job.data     = payload_byte;
                push_job.len      = payload_length;
                remain_next       = remain_reg - RW'(1);
                open_next         = !last_byte;
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            open_reg   <= open_next;
            remain_reg <= remain_next;
        end
    end

endmodule

FILE: rtl/sacf_queue.sv
// ---------------------------------------------------------------------------
// sacf_queue
// Small job queue that lets front and back stall on their own.
// ---------------------------------------------------------------------------
module sacf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  sacf_pkg::job_t    push_job,
    output logic              q_full,
    output logic              q_valid,
    output sacf_pkg::job_t    q_head,
    input  logic              pop,
    output logic [$clog2(sacf_pkg::QUEUE_DEPTH+1)-1:0] q_count
);

    localparam int DEPTH = sacf_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    sacf_pkg::job_t    entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push, do_pop;

    assign q_full  = count_reg == CW'(DEPTH);
    assign q_valid = count_reg != '0;
    assign q_head  = entry_reg[rd_ptr_reg];
    assign q_count = count_reg;
    assign do_push = push_valid && !q_full;
    assign do_pop  = pop && q_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

FILE: rtl/sacf_back.sv
// ---------------------------------------------------------------------------
// sacf_back
// Serializes jobs into frame bytes and accumulates the sum and add checks.
// ---------------------------------------------------------------------------
module sacf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        target_address,
    input  logic              q_valid,
    input  sacf_pkg::job_t    q_head,
    output logic              pop,
    output logic              mid_job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        tx_byte,
    output logic              frame_end
);

    typedef enum logic [5:0] {
        S_BEGIN = 6'b000001,
        S_ADDR  = 6'b000010,
        S_FUNC  = 6'b000100,
        S_LEN   = 6'b001000,
        S_SUM   = 6'b010000,
        S_ADD   = 6'b100000
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  add_reg, add_next;
    logic        out_valid_reg;
    logic [7:0]  tx_byte_reg;
    logic        frame_end_reg;
    logic        fire;
    logic [7:0]  byte_c;
    logic        end_c;
    logic        account;
    logic        restart;
    logic        done;
    logic [7:0]  acc_sum;
    logic [7:0]  acc_add;

    assign fire      = q_valid && (!out_valid_reg || out_ready);
    assign pop       = fire && done;
    assign mid_job   = state_reg != S_BEGIN;
    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign frame_end = frame_end_reg;

    // pick the byte for the current step
    always_comb
    begin
        state_next = state_reg;
        byte_c     = 8'd0;
        end_c      = 1'b0;
        account    = 1'b0;
        restart    = 1'b0;
        done       = 1'b0;
        case (state_reg)
            S_BEGIN:
            begin
                account = 1'b1;
                if (q_head.is_start)
                begin
                    byte_c     = sacf_pkg::HEADER_BYTE;
                    restart    = 1'b1;
                    state_next = S_ADDR;
                end
                else
                begin
                    byte_c = q_head.data;
                    if (q_head.close)
                        state_next = S_SUM;
                    else
                        done = 1'b1;
                end
            end
            S_ADDR:
            begin
                byte_c     = target_address;
                account    = 1'b1;
                state_next = S_FUNC;
            end
            S_FUNC:
            begin
                byte_c     = q_head.data;
                account    = 1'b1;
                state_next = S_LEN;
            end
            S_LEN:
            begin
                byte_c  = q_head.len;
                account = 1'b1;
                if (q_head.close)
                    state_next = S_SUM;
                else
                begin
                    state_next = S_BEGIN;
                    done       = 1'b1;
                end
            end
            S_SUM:
            begin
                byte_c     = sum_reg;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                byte_c     = add_reg;
                end_c      = 1'b1;
                state_next = S_BEGIN;
                done       = 1'b1;
            end
            default:
            begin
                state_next = S_BEGIN;
            end
        endcase
    end

    // check accumulation
    always_comb
    begin
        acc_sum  = (restart ? 8'd0 : sum_reg) + byte_c;
        acc_add  = (restart ? 8'd0 : add_reg) + acc_sum;
        sum_next = account ? acc_sum : sum_reg;
        add_next = account ? acc_add : add_reg;
    end

    // step state and checks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BEGIN;
            sum_reg   <= 8'd0;
            add_reg   <= 8'd0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            add_reg   <= add_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            tx_byte_reg   <= byte_c;
            frame_end_reg <= end_c;
        end
    end

endmodule

FILE: rtl/sum_add_check_frame_encoder_unit.sv
// ---------------------------------------------------------------------------
// sum_add_check_frame_encoder_unit
// Telemetry frame encoder: header, payload, sum check and add check bytes.
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  cfg      in         cfg_valid/cfg_ready  cfg_data (target address)
//  in       in         in_valid/in_ready    command, function_code,
//                                           payload_length, payload_byte
//  out      out        out_valid/out_ready  tx_byte, frame_end
//
//  the back end sends one byte per cycle while not stalled; a payload item
//  gives one byte, one that closes the frame three, a start item four or six
//  items enter at one per cycle while the two-entry job queue has room
//  reset clears frame tracking, checks, queue and the output register;
//  the target address resets to 0xFF
//  a stalled output holds the back end; the queue fills, then in_ready drops
// ---------------------------------------------------------------------------
module sum_add_check_frame_encoder_unit #(
    parameter int MAX_PAYLOAD = sacf_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] function_code,
    input  logic [7:0] payload_length,
    input  logic [7:0] payload_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] tx_byte,
    output logic       frame_end
);

    localparam int CW = $clog2(sacf_pkg::QUEUE_DEPTH + 1);

    logic [7:0]      target_reg;
    logic            push_valid;
    sacf_pkg::job_t  push_job;
    logic            q_full;
    logic            q_valid;
    sacf_pkg::job_t  q_head;
    logic            pop;
    logic            mid_job;
    logic [CW-1:0]   q_count;

    // target address register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= sacf_pkg::TARGET_RESET;
        else if (cfg_valid && cfg_ready)
            target_reg <= cfg_data;
    end

    // command front end
    sacf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .function_code  (function_code),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .q_full         (q_full),
        .push_valid     (push_valid),
        .push_job       (push_job)
    );

    // job queue
    sacf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .pop        (pop),
        .q_count    (q_count)
    );

    // byte serializer
    sacf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .target_address (target_reg),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .pop            (pop),
        .mid_job        (mid_job),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tx_byte        (tx_byte),
        .frame_end      (frame_end)
    );

    // a job is never pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push_valid |-> !q_full)
        else $error("job pushed into full queue");

    // the back end is only part way through a job while that job is queued
    assert property (@(posedge clk) disable iff (!rst_n) mid_job |-> q_valid)
        else $error("back end mid job with empty queue");

    // queue fill stays within its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CW'(sacf_pkg::QUEUE_DEPTH))
        else $error("queue count over depth");

    // a pop always comes with an available output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!out_valid || out_ready))
        else $error("job popped while output stalled");

endmodule

FILE: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the sum and add-check frame encoder. A built-in
// frame model predicts every byte sent, and a monitor compares each item
// on the output channel with the oldest predicted byte. Directed frames come
// first, then random traffic under several idle and stall mixes, target
// address changes between phases, and a long output hold-off.
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASE_ITEMS   = 70;
    localparam int MAX_REPORTS   = 40;

    // one predicted output item
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
    } frame_byte_t;

    // clock, reset and block ports
    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_valid      = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data       = 8'h00;
    logic       in_valid       = 1'b0;
    logic       in_ready;
    logic       command        = sacf_pkg::CMD_START;
    logic [7:0] function_code  = 8'h00;
    logic [7:0] payload_length = 8'h00;
    logic [7:0] payload_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready      = 1'b0;
    logic [7:0] tx_byte;
    logic       frame_end;

    // frame model state
    logic [7:0] target_addr = sacf_pkg::TARGET_RESET;
    logic       frame_open  = 1'b0;
    logic [4:0] bytes_left  = '0;
    logic [7:0] sum_chk     = '0;
    logic [7:0] add_chk     = '0;

    frame_byte_t pending_frame_bytes[$];

    // traffic shaping
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    logic hold_req     = 1'b0;
    int hold_left      = 0;

    // bookkeeping
    int cycle_count      = 0;
    int error_count      = 0;
    int items_accepted   = 0;
    int ignored_items    = 0;
    int frames_closed    = 0;
    int frames_abandoned = 0;
    int bytes_checked    = 0;
    int cfg_writes       = 0;

    sum_add_check_frame_encoder_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .function_code  (function_code),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tx_byte        (tx_byte),
        .frame_end      (frame_end)
    );

    // clock
    always #4 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still pending",
                     cycle_count, pending_frame_bytes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // mismatch report
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // frame model: queue one byte and fold it into the checks
    function automatic void put_byte(input logic [7:0] b, input logic account,
                                     input logic last);
        frame_byte_t fb;
        fb.tx_byte   = b;
        fb.frame_end = last;
        pending_frame_bytes.push_back(fb);
        if (account)
        begin
            sum_chk = sum_chk + b;
            add_chk = add_chk + sum_chk;
        end
    endfunction

    // frame model: both check bytes, then the frame closes
    function automatic void put_checks();
        put_byte(sum_chk, 1'b0, 1'b0);
        put_byte(add_chk, 1'b0, 1'b1);
        frame_open = 1'b0;
        bytes_left = '0;
        frames_closed++;
    endfunction

    // frame model: bytes caused by one accepted item
    function automatic void encode_item(input logic cmd, input logic [7:0] func,
                                        input logic [7:0] len, input logic [7:0] data);
        if (cmd == sacf_pkg::CMD_START)
        begin
            // too long: dropped, open frame untouched
            if (len > sacf_pkg::MAX_PAYLOAD_DEF)
            begin
                ignored_items++;
                return;
            end
            if (frame_open)
                frames_abandoned++;
            sum_chk    = '0;
            add_chk    = '0;
            frame_open = 1'b0;
            bytes_left = '0;
            put_byte(sacf_pkg::HEADER_BYTE, 1'b1, 1'b0);
            put_byte(target_addr, 1'b1, 1'b0);
            put_byte(func, 1'b1, 1'b0);
            put_byte(len, 1'b1, 1'b0);
            if (len == 8'd0)
                put_checks();
            else
            begin
                frame_open = 1'b1;
                bytes_left = len[4:0];
            end
        end
        else if (!frame_open)
            ignored_items++;
        else
        begin
            put_byte(data, 1'b1, 1'b0);
            bytes_left = bytes_left - 5'd1;
            if (bytes_left == 5'd0)
                put_checks();
        end
    endfunction

    // send one item, called and returning at a falling edge
    task automatic send_item(input logic cmd, input logic [7:0] func,
                             input logic [7:0] len, input logic [7:0] data);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        command        = cmd;
        function_code  = func;
        payload_length = len;
        payload_byte   = data;
        do
            @(posedge clk);
        while (!in_ready);
        items_accepted++;
        encode_item(cmd, func, len, data);
        @(negedge clk);
    endtask

    // start item with a random unused data field
    task automatic send_start(input logic [7:0] func, input logic [7:0] len);
        send_item(sacf_pkg::CMD_START, func, len, 8'($urandom));
    endtask

    // payload item with random unused fields
    task automatic send_payload(input logic [7:0] data);
        send_item(sacf_pkg::CMD_PAYLOAD, 8'($urandom), 8'($urandom), data);
    endtask

    // sender pause until every predicted byte has come out
    task automatic wait_all_delivered();
        int waited;
        waited   = 0;
        in_valid = 1'b0;
        while (pending_frame_bytes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        // dropped items may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // target address write, only while idle
    task automatic write_target(input logic [7:0] addr);
        wait_all_delivered();
        cfg_valid = 1'b1;
        cfg_data  = addr;
        do
            @(posedge clk);
        while (!cfg_ready);
        target_addr = addr;
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = 8'($urandom);
    endtask

    // receiver: random stalls and the long hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
            out_ready = ($urandom_range(99) >= sink_stall_pct);
    end

    // output monitor
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            bytes_checked++;
            if (pending_frame_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h frame_end %0b",
                                          tx_byte, frame_end));
            else
            begin
                want = pending_frame_bytes.pop_front();
                if (tx_byte !== want.tx_byte)
                    report_mismatch($sformatf("tx_byte %02h, want %02h",
                                              tx_byte, want.tx_byte));
                if (frame_end !== want.frame_end)
                    report_mismatch($sformatf("frame_end %0b, want %0b on byte %02h",
                                              frame_end, want.frame_end, want.tx_byte));
            end
        end
    end

    // directed frames against the reset target address
    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // empty payload, all-ones function code
        send_start(8'hFF, 8'd0);
        // too long, just over and at the top of the range
        send_start(8'h12, 8'(sacf_pkg::MAX_PAYLOAD_DEF + 1));
        send_start(8'h34, 8'hFF);
        // stray payload
        send_payload(8'h5A);
        // one payload byte at full scale
        send_start(8'h00, 8'd1);
        send_payload(8'hFF);
        // restart while open
        send_start(8'h81, 8'd3);
        send_payload(8'h00);
        send_start(8'h7E, 8'd0);
        // too-long start leaves the open frame alone
        send_start(8'h33, 8'd2);
        send_payload(8'h01);
        send_start(8'h44, 8'd200);
        send_payload(8'h80);
        // maximum length, abandoned by a short frame
        send_start(8'hC3, 8'(sacf_pkg::MAX_PAYLOAD_DEF));
        send_start(8'h3C, 8'd1);
        send_payload(8'h7F);
        wait_all_delivered();
    endtask

    // random frames, mostly well formed, some broken ones and noise
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int start_count;
        int r;
        int len;
        int cut;
        start_count    = items_accepted - ignored_items;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        while ((items_accepted - ignored_items) - start_count < n_items)
        begin
            r = $urandom_range(99);
            if (r < 6)
                send_payload(8'($urandom));
            else if (r < 12)
                send_start(8'($urandom),
                           8'($urandom_range(255, sacf_pkg::MAX_PAYLOAD_DEF + 1)));
            else
            begin
                r = $urandom_range(99);
                if (r < 70)
                    len = $urandom_range(8);
                else if (r < 85)
                    len = sacf_pkg::MAX_PAYLOAD_DEF;
                else
                    len = $urandom_range(sacf_pkg::MAX_PAYLOAD_DEF);
                // sometimes cut the frame short
                cut = ($urandom_range(99) < 10) ? $urandom_range(len) : len;
                send_start(8'($urandom), 8'(len));
                for (int i = 0; i < cut; i++)
                    send_payload(8'($urandom));
            end
        end
        wait_all_delivered();
    endtask

    // target address changes with one traffic mix per setting
    task automatic test_config_phases();
        write_target(8'h00);
        test_random_traffic(PHASE_ITEMS, 0, 0);
        write_target(8'($urandom));
        test_random_traffic(PHASE_ITEMS, 56, 0);
        write_target(sacf_pkg::HEADER_BYTE);
        test_random_traffic(PHASE_ITEMS, 0, 56);
        write_target(8'hFF);
        test_random_traffic(PHASE_ITEMS, 30, 30);
    endtask

    // long output hold-off while a maximum frame is offered back to back
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b1;
        send_start(8'($urandom), 8'(sacf_pkg::MAX_PAYLOAD_DEF));
        for (int i = 0; i < sacf_pkg::MAX_PAYLOAD_DEF; i++)
            send_payload(8'($urandom));
        wait_all_delivered();
    endtask

    // test sequence
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_config_phases();
        test_backpressure();

        wait_all_delivered();
        if (pending_frame_bytes.size() != 0)
            report_mismatch($sformatf("%0d predicted bytes never came out",
                                      pending_frame_bytes.size()));

        $display("covered %0d items (%0d dropped), %0d frames closed, %0d abandoned",
                 items_accepted, ignored_items, frames_closed, frames_abandoned);
        $display("checked %0d output bytes over %0d target address writes",
                 bytes_checked, cfg_writes);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
rtl/sacf_pkg.sv
rtl/sacf_front.sv
rtl/sacf_queue.sv
rtl/sacf_back.sv
rtl/sum_add_check_frame_encoder_unit.sv
sim/testbench.sv
